// ----- rtl/bucket_name_validator_defines.svh -----
// Assertion macros for the bucket name validator.
// Needs clk and arst_n in scope where used; no other dependencies.
`ifndef BUCKET_NAME_VALIDATOR_DEFINES_SVH
`define BUCKET_NAME_VALIDATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BNV_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BNV_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bnv_pkg.sv -----
// Shared constants, state type and reserved word tables for the bucket name validator.
// No dependencies.
package bnv_pkg;

	localparam int MAX_NAME_LEN = 63;
	localparam int MIN_NAME_LEN = 3;
	localparam int TAIL_DEPTH   = 8;
	localparam int QUAD_MAX     = 255;
	// count saturates at MAX_NAME_LEN + 1
	localparam int LEN_W        = $clog2(MAX_NAME_LEN + 2);

	localparam logic [7:0] CH_DOT  = 8'h2e;
	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_ZERO = 8'h30;

	// reserved prefixes, first character at index 0, padded with zeros
	localparam logic [7:0] PFX0 [4]  = '{"x", "n", "-", "-"};
	localparam logic [7:0] PFX1 [8]  = '{"s", "t", "h", "r", "e", "e", "-", 8'h00};
	localparam logic [7:0] PFX2 [16] = '{"a", "m", "z", "n", "-", "s", "3", "-",
		"d", "e", "m", "o", "-", 8'h00, 8'h00, 8'h00};
	localparam logic [LEN_W-1:0] PFX0_LEN = LEN_W'(4);
	localparam logic [LEN_W-1:0] PFX1_LEN = LEN_W'(7);
	localparam logic [LEN_W-1:0] PFX2_LEN = LEN_W'(13);

	// reserved suffixes, stored newest byte first to line up with the tail window
	localparam logic [7:0] SFX0_R [8] = '{"s", "a", "i", "l", "a", "3", "s", "-"};
	localparam logic [7:0] SFX1_R [7] = '{"3", "s", "-", "l", "o", "-", "-"};
	localparam logic [7:0] SFX2_R [6] = '{"3", "s", "-", "x", "-", "-"};
	localparam logic [7:0] SFX3_R [5] = '{"p", "a", "r", "m", "."};

	typedef struct packed {
		logic [LEN_W-1:0]                len;
		logic [7:0]                      first;
		logic [7:0]                      prev;
		logic                            broken;
		logic [TAIL_DEPTH-1:0][7:0]      tail;
		logic [2:0]                      pfx_alive;
		logic [1:0]                      q_seg;
		logic [1:0]                      q_dig;
		logic [9:0]                      q_val;
		logic                            q_poss;
	} bnv_state_t;

	localparam bnv_state_t ST_RESET = '{
		len: '0, first: '0, prev: '0, broken: 1'b0, tail: '0,
		pfx_alive: 3'b111, q_seg: '0, q_dig: '0, q_val: '0, q_poss: 1'b1
	};

endpackage

// ----- rtl/bnv_rules.sv -----
// Next-state and verdict logic for one name byte.
// Depends on bnv_pkg.
module bnv_rules (
	input  bnv_pkg::bnv_state_t cur,
	input  logic [7:0]          name_byte,
	output bnv_pkg::bnv_state_t nxt,
	output logic                verdict
);

	function automatic logic edge_bad(input logic [7:0] c);
		return (c == bnv_pkg::CH_DOT) || (c == bnv_pkg::CH_DASH);
	endfunction

	logic       is_digit;
	logic       allowed;
	logic [9:0] q_mul;
	logic       sfx0_hit, sfx1_hit, sfx2_hit, sfx3_hit;

	assign is_digit = (name_byte >= "0") && (name_byte <= "9");
	assign allowed  = ((name_byte >= "a") && (name_byte <= "z")) || is_digit ||
		edge_bad(name_byte);
	// value * 10 + digit; value stays below 100 whenever this is used
	assign q_mul = 10'({cur.q_val, 3'b000}) + 10'({cur.q_val, 1'b0}) +
		10'(name_byte[3:0] - bnv_pkg::CH_ZERO[3:0]);

	always_comb begin
		nxt = cur;

		if (!allowed)
			nxt.broken = 1'b1;
		if (cur.len != '0) begin
			if (((cur.prev == bnv_pkg::CH_DOT) && edge_bad(name_byte)) ||
				((cur.prev == bnv_pkg::CH_DASH) && (name_byte == bnv_pkg::CH_DOT)))
				nxt.broken = 1'b1;
		end else begin
			nxt.first = name_byte;
		end

		// prefix tracking
		if ((cur.len < bnv_pkg::PFX0_LEN) && (name_byte != bnv_pkg::PFX0[cur.len[1:0]]))
			nxt.pfx_alive[0] = 1'b0;
		if ((cur.len < bnv_pkg::PFX1_LEN) && (name_byte != bnv_pkg::PFX1[cur.len[2:0]]))
			nxt.pfx_alive[1] = 1'b0;
		if ((cur.len < bnv_pkg::PFX2_LEN) && (name_byte != bnv_pkg::PFX2[cur.len[3:0]]))
			nxt.pfx_alive[2] = 1'b0;

		// dotted-quad tracking
		if (is_digit) begin
			if (cur.q_dig == 2'd3) begin
				nxt.q_poss = 1'b0;
			end else begin
				nxt.q_val = q_mul;
				nxt.q_dig = cur.q_dig + 2'd1;
			end
		end else if (name_byte == bnv_pkg::CH_DOT) begin
			if ((cur.q_dig == '0) || (cur.q_val > 10'(bnv_pkg::QUAD_MAX)) ||
				(cur.q_seg == 2'd3))
				nxt.q_poss = 1'b0;
			else
				nxt.q_seg = cur.q_seg + 2'd1;
			nxt.q_dig = '0;
			nxt.q_val = '0;
		end else begin
			nxt.q_poss = 1'b0;
		end

		nxt.tail = {cur.tail[bnv_pkg::TAIL_DEPTH-2:0], name_byte};
		nxt.prev = name_byte;
		if (cur.len <= bnv_pkg::LEN_W'(bnv_pkg::MAX_NAME_LEN))
			nxt.len = cur.len + bnv_pkg::LEN_W'(1);
	end

	always_comb begin
		sfx0_hit = nxt.len >= bnv_pkg::LEN_W'(8);
		for (int k = 0; k < 8; k++)
			if (nxt.tail[k] != bnv_pkg::SFX0_R[k])
				sfx0_hit = 1'b0;
		sfx1_hit = nxt.len >= bnv_pkg::LEN_W'(7);
		for (int k = 0; k < 7; k++)
			if (nxt.tail[k] != bnv_pkg::SFX1_R[k])
				sfx1_hit = 1'b0;
		sfx2_hit = nxt.len >= bnv_pkg::LEN_W'(6);
		for (int k = 0; k < 6; k++)
			if (nxt.tail[k] != bnv_pkg::SFX2_R[k])
				sfx2_hit = 1'b0;
		sfx3_hit = nxt.len >= bnv_pkg::LEN_W'(5);
		for (int k = 0; k < 5; k++)
			if (nxt.tail[k] != bnv_pkg::SFX3_R[k])
				sfx3_hit = 1'b0;
	end

	always_comb begin
		verdict = !nxt.broken;
		if ((nxt.len < bnv_pkg::LEN_W'(bnv_pkg::MIN_NAME_LEN)) ||
			(nxt.len > bnv_pkg::LEN_W'(bnv_pkg::MAX_NAME_LEN)))
			verdict = 1'b0;
		if (edge_bad(nxt.first) || edge_bad(nxt.tail[0]))
			verdict = 1'b0;
		if (nxt.q_poss && (nxt.q_seg == 2'd3) && (nxt.q_dig != '0) &&
			(nxt.q_val <= 10'(bnv_pkg::QUAD_MAX)))
			verdict = 1'b0;
		if ((nxt.pfx_alive[0] && (nxt.len >= bnv_pkg::PFX0_LEN)) ||
			(nxt.pfx_alive[1] && (nxt.len >= bnv_pkg::PFX1_LEN)) ||
			(nxt.pfx_alive[2] && (nxt.len >= bnv_pkg::PFX2_LEN)))
			verdict = 1'b0;
		if (sfx0_hit || sfx1_hit || sfx2_hit || sfx3_hit)
			verdict = 1'b0;
	end

endmodule

// ----- rtl/bucket_name_validator.sv -----
// Top level of the streaming bucket name validator.
// Depends on bnv_pkg, bnv_rules and bucket_name_validator_defines.svh.
//
// Usage:
//  - Slave side: one name byte per request on s_tdata, s_tlast high on the final
//    byte. A request is taken when s_tvalid and s_tready are both high.
//  - Master side: one verdict request per name, m_tdata[0] = 1 when the name
//    passes every rule. Taken when m_tvalid and m_tready are both high.
//  - Throughput: one byte per cycle, sustained, including back-to-back names,
//    while no verdict waits on m_tready. Every byte passes through an input
//    register, then the rule logic updates the running state.
//  - Verdict path: the last byte passes the input register, then the result
//    register, whose valid flag drives m_tvalid.
//  - Stall: bytes that are not last keep flowing while a verdict waits. A last
//    byte parked in the input register waits until the result register is free,
//    and s_tready then drops until it moves.
//  - Reset: arst_n low clears all running state and the valid flags of the
//    input and result registers, not their payloads; then a new name may start.
//  - After each verdict all running state returns to its reset values.
`include "bucket_name_validator_defines.svh"

module bucket_name_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] name_byte
	input  logic       s_tlast,   // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] name_valid, [7:1] zero
);

	// input register
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// running state and result register
	bnv_pkg::bnv_state_t state_q;
	bnv_pkg::bnv_state_t state_nxt;
	logic                verdict;
	logic                out_vld_q;
	logic                out_ok_q;

	logic adv;  // byte in the input register is consumed this cycle

	assign adv      = vld_s1 && (!last_s1 || !out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;

	bnv_rules u_rules (
		.cur       (state_q),
		.name_byte (byte_s1),
		.nxt       (state_nxt),
		.verdict   (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bnv_pkg::ST_RESET;
		end else if (adv) begin
			state_q <= last_s1 ? bnv_pkg::ST_RESET : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_ok_q <= verdict;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'b0, out_ok_q};

	// checks
	`BNV_ASSERT_NOW(a_no_overwrite, out_vld_q && !m_tready, !(adv && last_s1), "verdict overwritten")
	`BNV_ASSERT_NEXT(a_verdict_shown, adv && last_s1, m_tvalid, "verdict not presented")
	`BNV_ASSERT_NEXT(a_no_spurious, !(adv && last_s1) && m_tready, !m_tvalid, "spurious verdict")
	`BNV_ASSERT_NEXT(a_state_cleared, adv && last_s1, state_q == bnv_pkg::ST_RESET, "state not cleared")
	`BNV_ASSERT_NOW(a_len_sat, 1'b1, state_q.len <= bnv_pkg::LEN_W'(bnv_pkg::MAX_NAME_LEN + 1), "length past saturation")

endmodule
